/* hdl/c80alu_pkg.sv */
// ----------------------------------------------------------------------------
// c80alu_pkg
// Shared types and constants for the 8080-style ALU pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c80alu_pkg;

    // operation codes; codes above DAD do nothing
    typedef enum logic [4:0] {
        OP_ADD = 5'd0,
        OP_ADC = 5'd1,
        OP_SUB = 5'd2,
        OP_SBB = 5'd3,
        OP_ANA = 5'd4,
        OP_XRA = 5'd5,
        OP_ORA = 5'd6,
        OP_CMP = 5'd7,
        OP_INR = 5'd8,
        OP_DCR = 5'd9,
        OP_DAA = 5'd10,
        OP_RLC = 5'd11,
        OP_RRC = 5'd12,
        OP_RAL = 5'd13,
        OP_RAR = 5'd14,
        OP_CMA = 5'd15,
        OP_STC = 5'd16,
        OP_CMC = 5'd17,
        OP_DAD = 5'd18
    } t_op;

    // flag byte bit positions: S Z 0 AC 0 P 1 CY
    localparam int unsigned FLAG_CY = 0;
    localparam int unsigned FLAG_P  = 2;
    localparam int unsigned FLAG_AC = 4;
    localparam int unsigned FLAG_Z  = 6;
    localparam int unsigned FLAG_S  = 7;

    // decimal adjust constants
    localparam logic [3:0] BCD_MAX    = 4'd9;
    localparam logic [3:0] ADJ_DIGIT  = 4'h6;

    // after first stage: operand arithmetic done, DAA and DAD not finished
    typedef struct packed {
        logic        is_daa;
        logic        is_dad;
        logic        is_cmp;
        logic [7:0]  acc;
        logic [7:0]  res;
        logic [7:0]  adj;
        logic        cy;
        logic        ac;
        logic        s;
        logic        z;
        logic        p;
        logic        szp;
        logic [8:0]  lo_sum;
        logic [15:0] hl;
        logic [7:0]  pr_hi;
    } t_s1;

    // after second stage: values final, S Z P still to be derived
    typedef struct packed {
        logic [7:0]  res_out;
        logic [7:0]  res_f;
        logic [15:0] wide;
        logic        cy;
        logic        ac;
        logic        s;
        logic        z;
        logic        p;
        logic        szp;
    } t_s2;

endpackage

`default_nettype wire

/* hdl/c80alu_flag_stage.sv */
// ----------------------------------------------------------------------------
// c80alu_flag_stage
// Last pipeline stage: derives sign, zero and parity and packs the flag byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c80alu_flag_stage (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire c80alu_pkg::t_s2  i_s2,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic [7:0]            o_result,
    output logic [15:0]           o_wide,
    output logic [7:0]            o_flags
);

    logic        r_valid;
    logic [7:0]  r_result;
    logic [15:0] r_wide;
    logic [7:0]  r_flags;
    logic [7:0]  n_flags;
    logic        s_f, z_f, p_f;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        s_f = i_s2.s;
        z_f = i_s2.z;
        p_f = i_s2.p;
        if (i_s2.szp) begin
            s_f = i_s2.res_f[7];
            z_f = (i_s2.res_f == 8'h00);
            p_f = ~^i_s2.res_f;
        end
        n_flags = 8'h02;
        n_flags[c80alu_pkg::FLAG_CY] = i_s2.cy;
        n_flags[c80alu_pkg::FLAG_P]  = p_f;
        n_flags[c80alu_pkg::FLAG_AC] = i_s2.ac;
        n_flags[c80alu_pkg::FLAG_Z]  = z_f;
        n_flags[c80alu_pkg::FLAG_S]  = s_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_s2.res_out;
            r_wide   <= i_s2.wide;
            r_flags  <= n_flags;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_wide   = r_wide;
    assign o_flags  = r_flags;

endmodule

`default_nettype wire

/* hdl/cpu8080_alu_with_flags.sv */
// ----------------------------------------------------------------------------
// cpu8080_alu_with_flags
// 8080-style ALU with flag generation, three register stages deep.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Signals                         Contents
// --------  ---  ------------------------------  ------------------------------
// input     in   i_s_axis_tvalid/o_s_axis_tready tuser: operation
//                i_s_axis_tdata (56b)            acc, operand, flags_in,
//                i_s_axis_tuser (5b)             pair_hl, pair_other
// output    out  o_m_axis_tvalid/i_m_axis_tready result, wide_result, flags_out
//                o_m_axis_tdata (32b)
//
// The accepting edge loads stage 1, and the result then passes through the stage 2 and
// stage 3 registers; one item per cycle while the output does not stall.
// Stage 1: operand add/sub, logic ops, rotates, INR/DCR, CMA/STC/CMC, DAA correction
//          selection, low byte of the DAD add.
// Stage 2: DAA correction add, high byte of the DAD add, result select.
// Stage 3: sign/zero/parity and flag byte packing (output register).
// Reset (synchronous, active low) clears the stage valid bits only.
// Each stage loads when it is empty or the stage after it moves, so a stall
// on the output backs up stage by stage without dropping or repeating items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpu8080_alu_with_flags (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] acc, [15:8] operand, [23:16] flags_in, [39:24] pair_hl,
    // [55:40] pair_other
    input  wire  [55:0] i_s_axis_tdata,
    // [4:0] operation
    input  wire  [4:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [7:0] result, [23:8] wide_result, [31:24] flags_out
    output logic [31:0] o_m_axis_tdata
);

    // input fields
    c80alu_pkg::t_op op;
    logic [7:0]  acc, opnd, fin;
    logic [15:0] hl, pr;

    assign op   = c80alu_pkg::t_op'(i_s_axis_tuser);
    assign acc  = i_s_axis_tdata[7:0];
    assign opnd = i_s_axis_tdata[15:8];
    assign fin  = i_s_axis_tdata[23:16];
    assign hl   = i_s_axis_tdata[39:24];
    assign pr   = i_s_axis_tdata[55:40];

    // stage handshake
    logic r_v1, r_v2;
    logic rdy2, rdy3, v3;
    logic ld1, ld2;

    c80alu_pkg::t_s1 r_s1, n_s1;
    c80alu_pkg::t_s2 r_s2, n_s2;

    assign rdy2            = !r_v2 || rdy3;
    assign o_s_axis_tready = !r_v1 || rdy2;
    assign ld1             = o_s_axis_tready;
    assign ld2             = rdy2;

    // ---------------- stage 1 ----------------
    logic       is_sub, cin;
    logic [7:0] opx;
    logic [8:0] sum9;
    logic [4:0] nib;
    logic [7:0] inc, dec;
    logic [3:0] lo, hi;
    logic       adj_lo, adj_hi;
    logic [4:0] daa_nib;

    always_comb begin
        is_sub = (op == c80alu_pkg::OP_SUB) || (op == c80alu_pkg::OP_SBB) ||
                 (op == c80alu_pkg::OP_CMP);
        opx    = is_sub ? ~opnd : opnd;
        case (op)
            c80alu_pkg::OP_ADC: cin = fin[c80alu_pkg::FLAG_CY];
            c80alu_pkg::OP_SUB: cin = 1'b1;
            c80alu_pkg::OP_CMP: cin = 1'b1;
            c80alu_pkg::OP_SBB: cin = ~fin[c80alu_pkg::FLAG_CY];
            default:            cin = 1'b0;
        endcase
        sum9 = {1'b0, acc} + {1'b0, opx} + {8'd0, cin};
        nib  = {1'b0, acc[3:0]} + {1'b0, opx[3:0]} + {4'd0, cin};
        inc  = opnd + 8'd1;
        dec  = opnd - 8'd1;

        // decimal adjust
        lo      = acc[3:0];
        hi      = acc[7:4];
        adj_lo  = fin[c80alu_pkg::FLAG_AC] || (lo > c80alu_pkg::BCD_MAX);
        adj_hi  = fin[c80alu_pkg::FLAG_CY] || (hi > c80alu_pkg::BCD_MAX) ||
                  ((hi == c80alu_pkg::BCD_MAX) && (lo > c80alu_pkg::BCD_MAX));
        daa_nib = {1'b0, lo} + {1'b0, (adj_lo ? c80alu_pkg::ADJ_DIGIT : 4'd0)};

        n_s1        = '0;
        n_s1.acc    = acc;
        n_s1.res    = acc;
        n_s1.cy     = fin[c80alu_pkg::FLAG_CY];
        n_s1.ac     = fin[c80alu_pkg::FLAG_AC];
        n_s1.s      = fin[c80alu_pkg::FLAG_S];
        n_s1.z      = fin[c80alu_pkg::FLAG_Z];
        n_s1.p      = fin[c80alu_pkg::FLAG_P];
        n_s1.lo_sum = {1'b0, hl[7:0]} + {1'b0, pr[7:0]};
        n_s1.hl     = hl;
        n_s1.pr_hi  = pr[15:8];
        n_s1.is_cmp = (op == c80alu_pkg::OP_CMP);

        case (op)
            c80alu_pkg::OP_ADD, c80alu_pkg::OP_ADC: begin
                n_s1.res = sum9[7:0];
                n_s1.cy  = sum9[8];
                n_s1.ac  = nib[4];
                n_s1.szp = 1'b1;
            end
            c80alu_pkg::OP_SUB, c80alu_pkg::OP_SBB, c80alu_pkg::OP_CMP: begin
                n_s1.res = sum9[7:0];
                n_s1.cy  = ~sum9[8];
                n_s1.ac  = nib[4];
                n_s1.szp = 1'b1;
            end
            c80alu_pkg::OP_ANA: begin
                n_s1.res = acc & opnd;
                n_s1.cy  = 1'b0;
                n_s1.ac  = acc[3] | opnd[3];
                n_s1.szp = 1'b1;
            end
            c80alu_pkg::OP_XRA: begin
                n_s1.res = acc ^ opnd;
                n_s1.cy  = 1'b0;
                n_s1.ac  = 1'b0;
                n_s1.szp = 1'b1;
            end
            c80alu_pkg::OP_ORA: begin
                n_s1.res = acc | opnd;
                n_s1.cy  = 1'b0;
                n_s1.ac  = 1'b0;
                n_s1.szp = 1'b1;
            end
            c80alu_pkg::OP_INR: begin
                n_s1.res = inc;
                n_s1.ac  = (inc[3:0] == 4'h0);
                n_s1.szp = 1'b1;
            end
            c80alu_pkg::OP_DCR: begin
                n_s1.res = dec;
                n_s1.ac  = (dec[3:0] != 4'hF);
                n_s1.szp = 1'b1;
            end
            c80alu_pkg::OP_DAA: begin
                n_s1.is_daa = 1'b1;
                n_s1.adj    = {(adj_hi ? c80alu_pkg::ADJ_DIGIT : 4'd0),
                               (adj_lo ? c80alu_pkg::ADJ_DIGIT : 4'd0)};
                n_s1.cy     = fin[c80alu_pkg::FLAG_CY] | adj_hi;
                n_s1.ac     = daa_nib[4];
                n_s1.szp    = 1'b1;
            end
            c80alu_pkg::OP_RLC: begin
                n_s1.res = {acc[6:0], acc[7]};
                n_s1.cy  = acc[7];
            end
            c80alu_pkg::OP_RRC: begin
                n_s1.res = {acc[0], acc[7:1]};
                n_s1.cy  = acc[0];
            end
            c80alu_pkg::OP_RAL: begin
                n_s1.res = {acc[6:0], fin[c80alu_pkg::FLAG_CY]};
                n_s1.cy  = acc[7];
            end
            c80alu_pkg::OP_RAR: begin
                n_s1.res = {fin[c80alu_pkg::FLAG_CY], acc[7:1]};
                n_s1.cy  = acc[0];
            end
            c80alu_pkg::OP_CMA: begin
                n_s1.res = ~acc;
            end
            c80alu_pkg::OP_STC: begin
                n_s1.cy = 1'b1;
            end
            c80alu_pkg::OP_CMC: begin
                n_s1.cy = ~fin[c80alu_pkg::FLAG_CY];
            end
            c80alu_pkg::OP_DAD: begin
                n_s1.is_dad = 1'b1;
            end
            default: begin
                // unused codes pass everything through
                n_s1.res = acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ld1) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1 && i_s_axis_tvalid) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------- stage 2 ----------------
    logic [8:0] hi_sum;

    always_comb begin
        hi_sum = {1'b0, r_s1.hl[15:8]} + {1'b0, r_s1.pr_hi} + {8'd0, r_s1.lo_sum[8]};

        n_s2.res_f = r_s1.is_daa ? (r_s1.acc + r_s1.adj) : r_s1.res;
        // compare sets flags from the difference but keeps the accumulator
        n_s2.res_out = r_s1.is_cmp ? r_s1.acc : n_s2.res_f;
        n_s2.wide    = r_s1.is_dad ? {hi_sum[7:0], r_s1.lo_sum[7:0]} : r_s1.hl;
        n_s2.cy      = r_s1.is_dad ? hi_sum[8] : r_s1.cy;
        n_s2.ac      = r_s1.ac;
        n_s2.s       = r_s1.s;
        n_s2.z       = r_s1.z;
        n_s2.p       = r_s1.p;
        n_s2.szp     = r_s1.szp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ld2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

    // ---------------- stage 3 ----------------
    logic [7:0]  out_result;
    logic [15:0] out_wide;
    logic [7:0]  out_flags;

    c80alu_flag_stage u_flag_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v2),
        .o_ready  (rdy3),
        .i_s2     (r_s2),
        .o_valid  (v3),
        .i_ready  (i_m_axis_tready),
        .o_result (out_result),
        .o_wide   (out_wide),
        .o_flags  (out_flags)
    );

    assign o_m_axis_tvalid = v3;
    assign o_m_axis_tdata  = {out_flags, out_wide, out_result};

endmodule

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking stream testbench for the 8080-style ALU with flags.
// A directed table covers the corner cases of every operation; random items
// follow. Each accepted item gets its expected result and flag byte from a
// local predictor, and the results are matched in order on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    // operation codes past DAD do nothing; used for the no-op cases
    localparam logic [4:0] OP_NONE_LO = 5'd19;
    localparam logic [4:0] OP_NONE_HI = 5'd31;

    // flag byte with only the always-one bit set
    localparam logic [7:0] FLAG_FIXED = 8'h02;

    localparam int LONG_HOLD   = 60;      // receiver hold-off, cycles
    localparam int CYCLE_LIMIT = 500000;  // run aborts past this
    localparam int DRAIN_WAIT  = 8;       // pipeline is 3 deep

    // one input item; tdata holds everything below op, acc in the low byte
    typedef struct packed {
        logic [4:0]  op;
        logic [15:0] pr;
        logic [15:0] hl;
        logic [7:0]  flags;
        logic [7:0]  operand;
        logic [7:0]  acc;
    } t_alu_in;

    // one result item, laid out exactly as o_m_axis_tdata
    typedef struct packed {
        logic [7:0]  flags;
        logic [15:0] wide;
        logic [7:0]  result;
    } t_alu_out;

    typedef struct {
        t_alu_in  x;
        bit       typed;
        t_alu_out y;
    } t_alu_row;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports (all DUT inputs driven to known values at time zero)
    // ------------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [7:0] acc, [15:8] operand, [23:16] flags_in, [39:24] pair_hl,
    // [55:40] pair_other
    logic [55:0] i_s_axis_tdata  = '0;
    // [4:0] operation
    logic [4:0]  i_s_axis_tuser  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [7:0] result, [23:8] wide_result, [31:24] flags_out
    logic [31:0] o_m_axis_tdata;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    cpu8080_alu_with_flags u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------------
    t_alu_out alu_results_due[$];   // expected results, oldest first
    t_alu_row dir_table[$];         // directed stimulus
    int       mismatches    = 0;
    int       cycles        = 0;
    bit       idle_en       = 1'b1; // random gaps/stalls on both sides
    bit       long_hold_req = 1'b0; // ask the receiver for one long hold-off
    int       hold_cnt      = 0;

    // ------------------------------------------------------------------------
    // Predictor: ALU result and flag byte for one item
    // ------------------------------------------------------------------------
    function automatic t_alu_out alu_predict(input t_alu_in x);
        logic        cy, p, ac, z, s, cin, upd_szp;
        logic [7:0]  res, nv, adj;
        logic [3:0]  lo, hi;
        logic [8:0]  sum;
        logic [4:0]  nib;
        logic [16:0] dsum;
        logic [15:0] wide;
        t_alu_out    y;
        cy      = x.flags[c80alu_pkg::FLAG_CY];
        p       = x.flags[c80alu_pkg::FLAG_P];
        ac      = x.flags[c80alu_pkg::FLAG_AC];
        z       = x.flags[c80alu_pkg::FLAG_Z];
        s       = x.flags[c80alu_pkg::FLAG_S];
        res     = x.acc;
        wide    = x.hl;
        upd_szp = 1'b0;
        case (x.op)
            c80alu_pkg::OP_ADD, c80alu_pkg::OP_ADC: begin
                cin     = (x.op == c80alu_pkg::OP_ADC) ? cy : 1'b0;
                sum     = {1'b0, x.acc} + {1'b0, x.operand} + {8'd0, cin};
                nib     = {1'b0, x.acc[3:0]} + {1'b0, x.operand[3:0]} + {4'd0, cin};
                ac      = nib[4];
                cy      = sum[8];
                res     = sum[7:0];
                upd_szp = 1'b1;
            end
            // subtract = add the complement; carry out is the inverted borrow
            c80alu_pkg::OP_SUB, c80alu_pkg::OP_SBB, c80alu_pkg::OP_CMP: begin
                nv      = ~x.operand;
                cin     = (x.op == c80alu_pkg::OP_SBB) ? ~cy : 1'b1;
                sum     = {1'b0, x.acc} + {1'b0, nv} + {8'd0, cin};
                nib     = {1'b0, x.acc[3:0]} + {1'b0, nv[3:0]} + {4'd0, cin};
                ac      = nib[4];
                cy      = ~sum[8];
                res     = sum[7:0];
                upd_szp = 1'b1;
            end
            c80alu_pkg::OP_ANA: begin
                ac      = x.acc[3] | x.operand[3];
                res     = x.acc & x.operand;
                cy      = 1'b0;
                upd_szp = 1'b1;
            end
            c80alu_pkg::OP_XRA: begin
                res     = x.acc ^ x.operand;
                cy      = 1'b0;
                ac      = 1'b0;
                upd_szp = 1'b1;
            end
            c80alu_pkg::OP_ORA: begin
                res     = x.acc | x.operand;
                cy      = 1'b0;
                ac      = 1'b0;
                upd_szp = 1'b1;
            end
            c80alu_pkg::OP_INR: begin
                res     = x.operand + 8'd1;
                ac      = (res[3:0] == 4'h0);
                upd_szp = 1'b1;
            end
            c80alu_pkg::OP_DCR: begin
                res     = x.operand - 8'd1;
                ac      = (res[3:0] != 4'hF);
                upd_szp = 1'b1;
            end
            c80alu_pkg::OP_DAA: begin
                lo  = x.acc[3:0];
                hi  = x.acc[7:4];
                adj = '0;
                if (ac || lo > c80alu_pkg::BCD_MAX) begin
                    adj[3:0] = c80alu_pkg::ADJ_DIGIT;
                end
                if (cy || hi > c80alu_pkg::BCD_MAX ||
                    (hi == c80alu_pkg::BCD_MAX && lo > c80alu_pkg::BCD_MAX)) begin
                    adj[7:4] = c80alu_pkg::ADJ_DIGIT;
                    cy       = 1'b1;
                end
                nib     = {1'b0, lo} + {1'b0, adj[3:0]};
                ac      = nib[4];
                res     = x.acc + adj;
                upd_szp = 1'b1;
            end
            c80alu_pkg::OP_RLC: begin
                cy  = x.acc[7];
                res = {x.acc[6:0], x.acc[7]};
            end
            c80alu_pkg::OP_RRC: begin
                cy  = x.acc[0];
                res = {x.acc[0], x.acc[7:1]};
            end
            c80alu_pkg::OP_RAL: begin
                res = {x.acc[6:0], cy};
                cy  = x.acc[7];
            end
            c80alu_pkg::OP_RAR: begin
                res = {cy, x.acc[7:1]};
                cy  = x.acc[0];
            end
            c80alu_pkg::OP_CMA: begin
                res = ~x.acc;
            end
            c80alu_pkg::OP_STC: begin
                cy = 1'b1;
            end
            c80alu_pkg::OP_CMC: begin
                cy = ~cy;
            end
            c80alu_pkg::OP_DAD: begin
                dsum = {1'b0, x.hl} + {1'b0, x.pr};
                cy   = dsum[16];
                wide = dsum[15:0];
            end
            default: begin
            end
        endcase
        if (upd_szp) begin
            s = res[7];
            z = (res == 8'h00);
            p = ~^res;
        end
        // compare sets flags from the difference but leaves A alone
        if (x.op == c80alu_pkg::OP_CMP) begin
            res = x.acc;
        end
        y.result        = res;
        y.wide          = wide;
        y.flags         = FLAG_FIXED;
        y.flags[c80alu_pkg::FLAG_CY] = cy;
        y.flags[c80alu_pkg::FLAG_P]  = p;
        y.flags[c80alu_pkg::FLAG_AC] = ac;
        y.flags[c80alu_pkg::FLAG_Z]  = z;
        y.flags[c80alu_pkg::FLAG_S]  = s;
        return y;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_pair();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_alu_in rand_alu_item();
        t_alu_in x;
        // a few percent of items carry an unused operation code
        if ($urandom_range(0, 99) < 5) begin
            x.op = 5'($urandom_range(int'(OP_NONE_LO), int'(OP_NONE_HI)));
        end else begin
            x.op = 5'($urandom_range(int'(c80alu_pkg::OP_ADD), int'(c80alu_pkg::OP_DAD)));
        end
        x.acc     = rand_byte();
        x.operand = rand_byte();
        x.flags   = 8'($urandom);
        x.hl      = rand_pair();
        x.pr      = rand_pair();
        // decimal adjust is most interesting right after a BCD add
        if (x.op == c80alu_pkg::OP_DAA && $urandom_range(0, 1) == 0) begin
            x.acc[7:4] = 4'($urandom_range(0, 9));
            x.acc[3:0] = 4'($urandom_range(0, 9));
        end
        return x;
    endfunction

    function automatic void add_row(input c80alu_pkg::t_op op, input logic [7:0] acc,
                                    input logic [7:0] operand, input logic [7:0] flags,
                                    input logic [15:0] hl, input logic [15:0] pr,
                                    input bit typed, input logic [7:0] res,
                                    input logic [15:0] wide, input logic [7:0] flags_out);
        t_alu_row r;
        r.x        = '{op: op, pr: pr, hl: hl, flags: flags, operand: operand, acc: acc};
        r.typed    = typed;
        r.y        = '{flags: flags_out, wide: wide, result: res};
        dir_table.push_back(r);
    endfunction

    // Called at a falling edge. Offers one item, waits for the handshake,
    // records the expectation, then optionally drops valid for a burst.
    task automatic offer_item(input t_alu_in x, input bit typed, input t_alu_out typed_y);
        i_s_axis_tuser  <= x.op;
        i_s_axis_tdata  <= {x.pr, x.hl, x.flags, x.operand, x.acc};
        i_s_axis_tvalid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        alu_results_due.push_back(typed ? typed_y : alu_predict(x));
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) begin
            offer_item(rand_alu_item(), 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        while (alu_results_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request.
    // Counted here so the sender keeps offering items while it lasts.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_m_axis_tready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_cnt      = LONG_HOLD - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            hold_cnt = $urandom_range(1, 15) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Output checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_alu_out got;
        t_alu_out want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (alu_results_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, got);
            end else begin
                want = alu_results_due.pop_front();
                check_field("result", 16'(want.result), 16'(got.result));
                check_field("wide_result", want.wide, got.wide);
                check_field("flags_out", 16'(want.flags), 16'(got.flags));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // directed table: op, acc, operand, flags, hl, pr, typed?, res, wide, flags
        // carry and half carry out of the top, zero result
        add_row(c80alu_pkg::OP_ADD, 8'hFF, 8'h01, 8'h00, 16'h1234, 16'hABCD, 1,
                8'h00, 16'h1234, 8'h57);
        // signed overflow, predictor only
        add_row(c80alu_pkg::OP_ADD, 8'h7F, 8'h01, 8'h00, 16'h1234, 16'hABCD, 0, '0, '0, '0);
        // carry in used
        add_row(c80alu_pkg::OP_ADC, 8'h00, 8'h00, 8'h01, 16'h1234, 16'hABCD, 1,
                8'h01, 16'h1234, 8'h02);
        add_row(c80alu_pkg::OP_ADC, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 0, '0, '0, '0);
        // borrow: carry set, all-ones result
        add_row(c80alu_pkg::OP_SUB, 8'h00, 8'h01, 8'h00, 16'h1234, 16'hABCD, 1,
                8'hFF, 16'h1234, 8'h87);
        // borrow in, no borrow out
        add_row(c80alu_pkg::OP_SBB, 8'h80, 8'h7F, 8'hFF, 16'h1234, 16'hABCD, 1,
                8'h00, 16'h1234, 8'h46);
        add_row(c80alu_pkg::OP_SBB, 8'h00, 8'hFF, 8'h00, 16'h0000, 16'h0000, 0, '0, '0, '0);
        // AC from bit 3 of either operand
        add_row(c80alu_pkg::OP_ANA, 8'hF0, 8'h08, 8'h00, 16'h1234, 16'hABCD, 1,
                8'h00, 16'h1234, 8'h56);
        add_row(c80alu_pkg::OP_XRA, 8'hFF, 8'hFF, 8'hFF, 16'h1234, 16'hABCD, 1,
                8'h00, 16'h1234, 8'h46);
        add_row(c80alu_pkg::OP_ORA, 8'h00, 8'h80, 8'h00, 16'h1234, 16'hABCD, 1,
                8'h80, 16'h1234, 8'h82);
        // compare leaves A as is
        add_row(c80alu_pkg::OP_CMP, 8'h55, 8'h55, 8'h00, 16'h1234, 16'hABCD, 1,
                8'h55, 16'h1234, 8'h56);
        // increment wraps, carry kept
        add_row(c80alu_pkg::OP_INR, 8'h3C, 8'hFF, 8'h01, 16'h1234, 16'hABCD, 1,
                8'h00, 16'h1234, 8'h57);
        add_row(c80alu_pkg::OP_DCR, 8'h3C, 8'h00, 8'h00, 16'h1234, 16'hABCD, 1,
                8'hFF, 16'h1234, 8'h86);
        // decimal adjust: low digit out of range with high digit 9, then both flags forcing it
        add_row(c80alu_pkg::OP_DAA, 8'h9A, 8'h00, 8'h00, 16'h1234, 16'hABCD, 1,
                8'h00, 16'h1234, 8'h57);
        add_row(c80alu_pkg::OP_DAA, 8'h00, 8'h00, 8'h11, 16'h1234, 16'hABCD, 1,
                8'h66, 16'h1234, 8'h07);
        // rotates touch carry only
        add_row(c80alu_pkg::OP_RLC, 8'h80, 8'h00, 8'h00, 16'h1234, 16'hABCD, 1,
                8'h01, 16'h1234, 8'h03);
        add_row(c80alu_pkg::OP_RRC, 8'h01, 8'h00, 8'hFF, 16'h1234, 16'hABCD, 1,
                8'h80, 16'h1234, 8'hD7);
        add_row(c80alu_pkg::OP_RAL, 8'h80, 8'h00, 8'h01, 16'h1234, 16'hABCD, 1,
                8'h01, 16'h1234, 8'h03);
        add_row(c80alu_pkg::OP_RAR, 8'h01, 8'h00, 8'h00, 16'h1234, 16'hABCD, 1,
                8'h00, 16'h1234, 8'h03);
        // complement with only the unused flag bits set: flags normalized
        add_row(c80alu_pkg::OP_CMA, 8'h0F, 8'h00, 8'h28, 16'h1234, 16'hABCD, 1,
                8'hF0, 16'h1234, 8'h02);
        add_row(c80alu_pkg::OP_STC, 8'h3C, 8'h00, 8'h00, 16'h1234, 16'hABCD, 1,
                8'h3C, 16'h1234, 8'h03);
        add_row(c80alu_pkg::OP_CMC, 8'h3C, 8'h00, 8'hFF, 16'h1234, 16'hABCD, 1,
                8'h3C, 16'h1234, 8'hD6);
        // 16-bit add: carry out of the top, then zero plus zero
        add_row(c80alu_pkg::OP_DAD, 8'hA5, 8'h00, 8'h00, 16'hFFFF, 16'h0001, 1,
                8'hA5, 16'h0000, 8'h03);
        add_row(c80alu_pkg::OP_DAD, 8'hA5, 8'h00, 8'hFF, 16'h0000, 16'h0000, 1,
                8'hA5, 16'h0000, 8'hD6);
        // unused operation codes pass everything through
        dir_table.push_back('{x: '{op: OP_NONE_LO, pr: 16'h5555, hl: 16'hAAAA, flags: 8'hFF,
                                   operand: 8'h55, acc: 8'hAA},
                              typed: 1'b1,
                              y: '{flags: 8'hD7, wide: 16'hAAAA, result: 8'hAA}});
        dir_table.push_back('{x: '{op: OP_NONE_HI, pr: 16'hAAAA, hl: 16'h5555, flags: 8'h00,
                                   operand: 8'hAA, acc: 8'h55},
                              typed: 1'b1,
                              y: '{flags: 8'h02, wide: 16'h5555, result: 8'h55}});

        // reset asserted from time zero, released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_table[i]) begin
            offer_item(dir_table[i].x, dir_table[i].typed, dir_table[i].y);
        end

        run_random(1200);

        // back-pressure: receiver holds off while the sender keeps going,
        // so the pipeline fills and input ready drops
        idle_en       = 1'b0;
        long_hold_req = 1'b1;
        run_random(40);
        idle_en = 1'b1;

        // sender pauses until every result is back
        i_s_axis_tvalid <= 1'b0;
        wait_drained();
        @(negedge i_clk);

        run_random(500);

        // closing stretch at full rate on both sides
        idle_en = 1'b0;
        run_random(200);
        i_s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/c80alu_pkg.sv
hdl/c80alu_flag_stage.sv
hdl/cpu8080_alu_with_flags.sv
dv/tb.sv
